// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radix digit emitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SRDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg
// Types and constants of the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int VALUE_BITS = 64;
    localparam int FEED_W     = 7;      // counts fed magnitude bits, 0..64
    localparam int CNT_W      = 7;      // character counts, 0..64
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;

    localparam logic [7:0]         PAD_CHAR  = 8'h30;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;

    // configuration register indexes
    localparam logic [1:0] REG_RADIX      = 2'd0;
    localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [6:0]                   min_digits;
    } srde_in_t;

    typedef struct packed {
        logic [7:0]       char_code;
        logic             is_last;
        logic [CNT_W-1:0] total_chars;
    } srde_out_t;

    // carry handed from one digit cell to the next
    typedef struct packed {
        logic valid;
        logic carry;
    } srde_carry_t;

    // row-wide cell control
    typedef struct packed {
        logic clear;
        logic shift;
    } srde_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PAD,
        ST_DIGS
    } srde_state_t;

endpackage

// File: rtl/srde_cell.sv
// ----------------------------------------------------------------------------
// srde_cell
// One digit of the conversion row: doubles its digit and adds the incoming
// carry, reduces by the radix, and passes the carry on; also shifts digits up.
// ----------------------------------------------------------------------------
module srde_cell
    import srde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [RADIX_W-1:0]   radix,
    input  srde_ctl_t            ctl,
    input  logic [DIGIT_W-1:0]   lower_digit,
    input  srde_carry_t          carry_in,
    output logic [DIGIT_W-1:0]   digit,
    output srde_carry_t          carry_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    srde_carry_t        carry_reg;
    srde_carry_t        carry_next;
    logic [RADIX_W-1:0] dbl;
    logic [RADIX_W-1:0] dbl_sub;
    logic               ge;

    assign dbl     = {digit_reg, carry_in.carry};
    assign ge      = (dbl >= radix);
    assign dbl_sub = dbl - radix;

    always_comb
    begin
        carry_next.valid = carry_in.valid;
        carry_next.carry = carry_in.valid & ge;
        digit_next       = digit_reg;
        priority if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.shift)
        begin
            digit_next = lower_digit;
        end
        else if (carry_in.valid)
        begin
            digit_next = ge ? dbl_sub[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;

endmodule

// File: rtl/signed_radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// Writes the magnitude of a signed 64-bit value as characters in radix 2..16,
// most significant digit first, left-padded with '0' to a minimum count.
// ----------------------------------------------------------------------------
// Usage: pulse start with the operand while busy is low. The unit then stays
// busy for one conversion: first the magnitude bits ripple through the row of
// digit cells (one cell per digit, the carry wave moves one cell per cycle),
// then leading zero digits are shifted out of the top cell, then the
// characters are emitted, one per cycle. Each character appears on result
// for exactly one cycle with result_valid high; the receiver cannot hold
// results off, so it must take one character per cycle. The final character
// carries is_last and the total count; a zero value with min_digits of zero
// produces no transaction at all. The sign is never emitted. Configuration
// writes are taken only while idle (cfg_ready equals not busy); radix values
// below 2 act as 2, above 16 as 16.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_unit
    import srde_pkg::*;
#(
    parameter int MAX_DIGITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  srde_in_t    operand,
    output logic        result_valid,
    output srde_out_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LZ_W = $clog2(MAX_DIGITS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RADIX_W-1:0] radix_reg;
    logic [63:0]        chars_low_reg;
    logic [63:0]        chars_high_reg;
    logic [RADIX_W-1:0] radix_eff;
    logic               cfg_write;

    assign cfg_ready = !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RST;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                REG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                REG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:        ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // clamp the base into 2..16
    always_comb
    begin
        priority if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state and counters
    // ------------------------------------------------------------------
    srde_state_t              state_reg;
    srde_state_t              state_next;
    logic [VALUE_BITS-1:0]    mag_reg;
    logic [VALUE_BITS-1:0]    mag_next;
    logic [FEED_W-1:0]        feed_cnt_reg;
    logic [FEED_W-1:0]        feed_cnt_next;
    logic [LZ_W-1:0]          lz_reg;
    logic [LZ_W-1:0]          lz_next;
    logic [6:0]               min_reg;
    logic [6:0]               min_next;
    logic [CNT_W-1:0]         pad_reg;
    logic [CNT_W-1:0]         pad_next;
    logic [CNT_W-1:0]         dig_reg;
    logic [CNT_W-1:0]         dig_next;
    logic [CNT_W-1:0]         total_reg;
    logic [CNT_W-1:0]         total_next;
    srde_out_t                result_reg;
    srde_out_t                result_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;

    logic                     accept;
    logic                     feeding;
    logic                     conv_done;
    logic                     norm_done;
    logic [CNT_W-1:0]         sig_digits;
    logic [CNT_W-1:0]         pad_calc;
    logic [CNT_W-1:0]         total_calc;
    logic [VALUE_BITS-1:0]    mag_in;
    logic [6:0]               min_sat;
    logic [7:0]               digit_char;
    logic [127:0]             char_table;

    // ------------------------------------------------------------------
    // Digit cell row; cell 0 is the least significant digit
    // ------------------------------------------------------------------
    srde_ctl_t                cell_ctl;
    srde_carry_t              feed;
    srde_carry_t              carry_row [MAX_DIGITS];
    logic [DIGIT_W-1:0]       digit_row [MAX_DIGITS];
    logic [DIGIT_W-1:0]       top_digit;

    for (genvar k = 0; k < MAX_DIGITS; k++)
    begin : g_cell
        srde_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .radix       (radix_eff),
            .ctl         (cell_ctl),
            .lower_digit ((k == 0) ? '0 : digit_row[(k == 0) ? 0 : k - 1]),
            .carry_in    ((k == 0) ? feed : carry_row[(k == 0) ? 0 : k - 1]),
            .digit       (digit_row[k]),
            .carry_out   (carry_row[k])
        );
    end

    assign top_digit = digit_row[MAX_DIGITS-1];

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign feeding      = (state_reg == ST_CONV) && (feed_cnt_reg < FEED_W'(VALUE_BITS));
    // the wave has left the top cell once feeding is over and its carry is idle
    assign conv_done    = (feed_cnt_reg == FEED_W'(VALUE_BITS))
                          && !carry_row[MAX_DIGITS-1].valid;
    assign norm_done    = (top_digit != '0) || (lz_reg == LZ_W'(MAX_DIGITS));

    // magnitude, exact for the most negative value
    assign mag_in  = operand.value[VALUE_BITS-1] ? ('0 - VALUE_BITS'(operand.value))
                                                 : VALUE_BITS'(operand.value);
    assign min_sat = (operand.min_digits > 7'(MAX_DIGITS)) ? 7'(MAX_DIGITS)
                                                           : operand.min_digits;

    assign sig_digits = CNT_W'(MAX_DIGITS) - CNT_W'(lz_reg);
    assign pad_calc   = (min_reg > sig_digits) ? (min_reg - sig_digits) : '0;
    assign total_calc = pad_calc + sig_digits;

    assign char_table = {chars_high_reg, chars_low_reg};
    assign digit_char = char_table[{top_digit, 3'b000} +: 8];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    priority if (total_calc == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pad_calc != '0)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_DIGS;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_reg == CNT_W'(1))
                begin
                    state_next = (dig_reg != '0) ? ST_DIGS : ST_IDLE;
                end
            end
            ST_DIGS:
            begin
                if (dig_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Row control: clear on accept, shift while normalizing or digit emitting
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_ctl.clear = 1'b0;
        cell_ctl.shift = 1'b0;
        feed.valid     = feeding;
        feed.carry     = mag_reg[VALUE_BITS-1];
        unique case (state_reg)
            ST_IDLE: cell_ctl.clear = accept;
            ST_NORM: cell_ctl.shift = !norm_done;
            ST_DIGS: cell_ctl.shift = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        mag_next          = mag_reg;
        feed_cnt_next     = feed_cnt_reg;
        lz_next           = lz_reg;
        min_next          = min_reg;
        pad_next          = pad_reg;
        dig_next          = dig_reg;
        total_next        = total_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next      = mag_in;
                    min_next      = min_sat;
                    feed_cnt_next = '0;
                    lz_next       = '0;
                end
            end
            ST_CONV:
            begin
                // hand the magnitude to cell 0, most significant bit first
                if (feeding)
                begin
                    mag_next      = {mag_reg[VALUE_BITS-2:0], 1'b0};
                    feed_cnt_next = feed_cnt_reg + FEED_W'(1);
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    pad_next   = pad_calc;
                    dig_next   = sig_digits;
                    total_next = total_calc;
                end
                else
                begin
                    lz_next = lz_reg + LZ_W'(1);
                end
            end
            ST_PAD:
            begin
                result_valid_next       = 1'b1;
                result_next.char_code   = PAD_CHAR;
                result_next.is_last     = (pad_reg == CNT_W'(1)) && (dig_reg == '0);
                result_next.total_chars = result_next.is_last ? total_reg : '0;
                pad_next                = pad_reg - CNT_W'(1);
            end
            ST_DIGS:
            begin
                result_valid_next       = 1'b1;
                result_next.char_code   = digit_char;
                result_next.is_last     = (dig_reg == CNT_W'(1));
                result_next.total_chars = result_next.is_last ? total_reg : '0;
                dig_next                = dig_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            feed_cnt_reg     <= '0;
            lz_reg           <= '0;
            pad_reg          <= '0;
            dig_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            feed_cnt_reg     <= feed_cnt_next;
            lz_reg           <= lz_next;
            pad_reg          <= pad_next;
            dig_reg          <= dig_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        min_reg    <= min_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `SRDE_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, accept, state_reg == ST_CONV, "accepted transaction did not enter conversion")
    `SRDE_ASSERT_IMPL(a_strobe_from_emit, clk, rst_n, result_valid, $past(state_reg) == ST_PAD || $past(state_reg) == ST_DIGS, "result strobe outside emission")
    `SRDE_ASSERT_IMPL(a_last_has_count, clk, rst_n, result_valid && result.is_last, result.total_chars != '0, "final character without a count")
    `SRDE_ASSERT_IMPL(a_digit_below_radix, clk, rst_n, state_reg == ST_DIGS, top_digit < radix_eff, "emitted digit not below the radix")

endmodule
